/* sv/qtrm_pkg.sv */
// Shared widths, types and entry indexes for the quaternion to rotation matrix core.
package qtrm_pkg;

  localparam int DIN_W         = 16;
  localparam int PROD_W        = 2 * DIN_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int NUM_W         = PROD_W + 2;
  localparam int N_ENT         = 9;
  localparam int OUT_W         = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_TDATA_W    = 4 * DIN_W;
  localparam int OUT_TDATA_W   = N_ENT * OUT_W;

  // matrix entry positions, row-major
  localparam int E11 = 0;
  localparam int E12 = 1;
  localparam int E13 = 2;
  localparam int E21 = 3;
  localparam int E22 = 4;
  localparam int E23 = 5;
  localparam int E31 = 6;
  localparam int E32 = 7;
  localparam int E33 = 8;

  typedef logic signed [DIN_W-1:0]  comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic        [SUM_W-1:0]  mag_t;
  typedef logic        [OUT_W-1:0]  ent_t;

endpackage

/* sv/quaternion_to_rotation_matrix_core.sv */
// Pipelined quaternion to 3x3 rotation matrix converter with exact rounded division.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: quat_w, quat_x, quat_y, quat_z
//  out_    | out | out_tvalid/out_tready| out_tdata: m11..m33, out_tuser: zero_norm
//
// One beat per cycle while out_tready is high; the restoring division yields one quotient bit
// per stage for all nine entries.
// Reset clears only the stage valid bits.
// A full stage holds while its successor is full and stalled; empty stages fill in,
// so the input keeps taking beats while the output waits, as long as a bubble remains.
module quaternion_to_rotation_matrix_core #(
  parameter int FRAC_BITS = qtrm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [qtrm_pkg::IN_TDATA_W-1:0]    in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [qtrm_pkg::OUT_TDATA_W-1:0]   out_tdata,  // m11,m12,m13,m21,m22,m23,m31,m32,m33
  output logic                               out_tuser   // zero_norm
);
  import qtrm_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int DIV_N = FRAC_BITS + 1;
  localparam int NSTG  = DIV_N + 4;
  localparam int QX    = (QW + 1 > OUT_W + 1) ? QW + 1 : OUT_W + 1;
  localparam logic [QX-1:0] ONE_X     = {{(QX-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [QX-1:0] POS_MAX_X = QX'((2 ** (OUT_W - 1)) - 1);
  localparam logic [QX-1:0] NEG_MAX_X = QX'(2 ** (OUT_W - 1));
  localparam ent_t ENT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam ent_t ENT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // ---------------- valid chain ----------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_en
      assign en[k] = out_tready | ~(&v_r[NSTG-1:k]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NSTG-1];

  // ---------------- stage 0: products ----------------
  comp_t qw, qx, qy, qz;
  assign qw = in_tdata[DIN_W-1:0];
  assign qx = in_tdata[2*DIN_W-1:DIN_W];
  assign qy = in_tdata[3*DIN_W-1:2*DIN_W];
  assign qz = in_tdata[4*DIN_W-1:3*DIN_W];

  prod_t ww_r, xx_r, yy_r, zz_r, xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww_r <= qw * qw;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      zz_r <= qz * qz;
      xy_r <= qx * qy;
      zw_r <= qz * qw;
      xz_r <= qx * qz;
      yw_r <= qy * qw;
      yz_r <= qy * qz;
      xw_r <= qx * qw;
    end
  end

  // ---------------- stage 1: norm and numerators ----------------
  mag_t s_nxt, s_r;
  num_t num_nxt [N_ENT];
  num_t num_r   [N_ENT];
  num_t eww, exx, eyy, ezz, exy, ezw, exz, eyw, eyz, exw;

  always_comb begin
    eww = NUM_W'(ww_r);
    exx = NUM_W'(xx_r);
    eyy = NUM_W'(yy_r);
    ezz = NUM_W'(zz_r);
    exy = NUM_W'(xy_r);
    ezw = NUM_W'(zw_r);
    exz = NUM_W'(xz_r);
    eyw = NUM_W'(yw_r);
    eyz = NUM_W'(yz_r);
    exw = NUM_W'(xw_r);
    // squares are non-negative, so the low bits add as unsigned
    s_nxt = {2'b00, ww_r[PROD_W-2:0]} + {2'b00, xx_r[PROD_W-2:0]}
          + {2'b00, yy_r[PROD_W-2:0]} + {2'b00, zz_r[PROD_W-2:0]};
    num_nxt[E11] = eww + exx - eyy - ezz;
    num_nxt[E12] = (exy - ezw) <<< 1;
    num_nxt[E13] = (exz + eyw) <<< 1;
    num_nxt[E21] = (exy + ezw) <<< 1;
    num_nxt[E22] = eww - exx + eyy - ezz;
    num_nxt[E23] = (eyz - exw) <<< 1;
    num_nxt[E31] = (exz - eyw) <<< 1;
    num_nxt[E32] = (eyz + exw) <<< 1;
    num_nxt[E33] = eww - exx - eyy + ezz;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s_r <= s_nxt;
      for (int i = 0; i < N_ENT; i++) begin
        num_r[i] <= num_nxt[i];
      end
    end
  end

  // ---------------- stage 2: sign, magnitude, zero check ----------------
  // chain index j holds the item after j division steps; index 0 is stage 2
  mag_t             den_r  [DIV_N+1];
  mag_t             rem_r  [DIV_N+1][N_ENT];
  logic [QW-1:0]    q_r    [DIV_N+1][N_ENT];
  logic [N_ENT-1:0] neg_r  [DIV_N+1];
  logic             zero_r [DIV_N+1];

  num_t             absn   [N_ENT];
  mag_t             mag_nxt[N_ENT];
  logic [N_ENT-1:0] neg_nxt;

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      neg_nxt[i] = num_r[i][NUM_W-1];
      absn[i]    = neg_nxt[i] ? -num_r[i] : num_r[i];
      mag_nxt[i] = (absn[i][SUM_W-1:0] > s_r) ? s_r : absn[i][SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      den_r[0]  <= s_r;
      neg_r[0]  <= neg_nxt;
      zero_r[0] <= (s_r == '0);
      for (int i = 0; i < N_ENT; i++) begin
        rem_r[0][i] <= mag_nxt[i];
        q_r[0][i]   <= '0;
      end
    end
  end

  // ---------------- stages 3..: one quotient bit per stage ----------------
  genvar j;
  generate
    for (j = 0; j < DIV_N; j++) begin : g_div
      logic [SUM_W:0]   t    [N_ENT];
      logic [SUM_W:0]   diff [N_ENT];
      logic [N_ENT-1:0] qbit;

      always_comb begin
        for (int i = 0; i < N_ENT; i++) begin
          // first step yields the integer bit, so no shift there
          t[i]    = (j == 0) ? {1'b0, rem_r[j][i]} : {rem_r[j][i], 1'b0};
          diff[i] = t[i] - {1'b0, den_r[j]};
          qbit[i] = (t[i] >= {1'b0, den_r[j]});
        end
      end

      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          den_r[j+1]  <= den_r[j];
          neg_r[j+1]  <= neg_r[j];
          zero_r[j+1] <= zero_r[j];
          for (int i = 0; i < N_ENT; i++) begin
            rem_r[j+1][i] <= qbit[i] ? diff[i][SUM_W-1:0] : t[i][SUM_W-1:0];
            q_r[j+1][i]   <= {q_r[j][i][QW-2:0], qbit[i]};
          end
        end
      end
    end
  endgenerate

  // ---------------- last stage: round, sign, saturate ----------------
  logic [SUM_W:0]          r2   [N_ENT];
  logic [QX-1:0]           qf   [N_ENT];
  logic [QX-1:0]           nq   [N_ENT];
  ent_t                    ent  [N_ENT];
  logic [OUT_TDATA_W-1:0]  out_data_nxt, out_data_r;
  logic                    out_zero_r;

  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < N_ENT; i++) begin
      // round half up on the magnitude: remainder at least half the divisor
      r2[i] = {rem_r[DIV_N][i], 1'b0};
      qf[i] = QX'(q_r[DIV_N][i]) + QX'(r2[i] >= {1'b0, den_r[DIV_N]});
      if (qf[i] > ONE_X) begin
        qf[i] = ONE_X;
      end
      nq[i] = -qf[i];
      if (zero_r[DIV_N]) begin
        ent[i] = '0;
      end else if (!neg_r[DIV_N][i]) begin
        ent[i] = (qf[i] > POS_MAX_X) ? ENT_MAX : qf[i][OUT_W-1:0];
      end else begin
        ent[i] = (qf[i] > NEG_MAX_X) ? ENT_MIN : nq[i][OUT_W-1:0];
      end
      out_data_nxt[i*OUT_W +: OUT_W] = ent[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_data_r <= out_data_nxt;
      out_zero_r <= zero_r[DIV_N];
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_zero_r;

  // ---------------- checks ----------------
  localparam int HI_LIM = (FRAC_BITS >= OUT_W - 1) ? (2 ** (OUT_W - 1)) - 1 : 2 ** FRAC_BITS;
  localparam int LO_LIM = (FRAC_BITS >= OUT_W - 1) ? 2 ** (OUT_W - 1) : 2 ** FRAC_BITS;
  localparam logic signed [OUT_W:0] HI17 = (OUT_W+1)'(HI_LIM);
  localparam logic signed [OUT_W:0] LO17 = (OUT_W+1)'(-LO_LIM);

  logic signed [OUT_W:0] chk_e;
  logic                  range_ok;

  always_comb begin
    range_ok = 1'b1;
    chk_e    = '0;
    for (int i = 0; i < N_ENT; i++) begin
      chk_e = {out_data_r[i*OUT_W + OUT_W - 1], out_data_r[i*OUT_W +: OUT_W]};
      if (chk_e > HI17 || chk_e < LO17) begin
        range_ok = 1'b0;
      end
    end
  end

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero-norm beat carries nonzero entries");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> range_ok)
    else $error("matrix entry outside saturation limits");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat not captured in first stage");

  a_backpressure_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input stalled while pipeline has room");

endmodule

/* tb/rotation_matrix_checker.sv */
// Watches both streams, predicts each rotation matrix and compares it with the result beat.
`timescale 1ns / 1ps

module rotation_matrix_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [qtrm_pkg::IN_TDATA_W-1:0]  in_tdata,   // quat_w, quat_x, quat_y, quat_z
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [qtrm_pkg::OUT_TDATA_W-1:0] out_tdata,  // m11,m12,m13,m21,m22,m23,m31,m32,m33
  input  logic                             out_tuser,  // zero_norm
  output int                               mismatches,
  output int                               outstanding
);
  import qtrm_pkg::*;

  typedef struct packed {
    logic [OUT_TDATA_W-1:0] ents;
    logic                   zero_norm;
  } rot_mat_t;

  rot_mat_t expected_mats[$];

  // round(num * 2^FRAC / s) half away from zero, clamped to +-1 and to 16 bits
  function automatic ent_t scaled_entry(longint num, longint s);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    longint unsigned one;
    longint          r;
    mag = (num < 0) ? -num : num;
    den = s;
    one = 64'd1 << FRAC_BITS_DEF;
    if (mag > den) mag = den;
    q = (2 * (mag << FRAC_BITS_DEF) + den) / (2 * den);
    if (q > one) q = one;
    r = (num < 0) ? -longint'(q) : longint'(q);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  function automatic rot_mat_t quat_to_matrix(logic [IN_TDATA_W-1:0] beat);
    comp_t    cw, cx, cy, cz;
    longint   w, x, y, z, ww, xx, yy, zz, s;
    longint   num[N_ENT];
    rot_mat_t m;
    cw = beat[0*DIN_W +: DIN_W];
    cx = beat[1*DIN_W +: DIN_W];
    cy = beat[2*DIN_W +: DIN_W];
    cz = beat[3*DIN_W +: DIN_W];
    w = cw;
    x = cx;
    y = cy;
    z = cz;
    ww = w * w;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    s = ww + xx + yy + zz;
    m = '0;
    if (s == 0) begin
      m.zero_norm = 1'b1;
      return m;
    end
    num[E11] = ww + xx - yy - zz;
    num[E12] = 2 * (x * y - z * w);
    num[E13] = 2 * (x * z + y * w);
    num[E21] = 2 * (x * y + z * w);
    num[E22] = ww - xx + yy - zz;
    num[E23] = 2 * (y * z - x * w);
    num[E31] = 2 * (x * z - y * w);
    num[E32] = 2 * (y * z + x * w);
    num[E33] = ww - xx - yy + zz;
    for (int i = 0; i < N_ENT; i++) m.ents[i*OUT_W +: OUT_W] = scaled_entry(num[i], s);
    return m;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    rot_mat_t exp_m;
    ent_t     e_exp, e_act;
    int       errs;
    errs = 0;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_mats.push_back(quat_to_matrix(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_mats.size() == 0) begin
          $error("result beat with no quaternion pending");
          errs++;
        end else begin
          exp_m = expected_mats.pop_front();
          for (int i = 0; i < N_ENT; i++) begin
            e_exp = exp_m.ents[i*OUT_W +: OUT_W];
            e_act = out_tdata[i*OUT_W +: OUT_W];
            if (e_act !== e_exp) begin
              $error("m%0d%0d expected %0d got %0d", i / 3 + 1, i % 3 + 1,
                     $signed(e_exp), $signed(e_act));
              errs++;
            end
          end
          if (out_tuser !== exp_m.zero_norm) begin
            $error("zero_norm expected %0d got %0d", exp_m.zero_norm, out_tuser);
            errs++;
          end
        end
      end
    end
    mismatches  <= mismatches + errs;
    outstanding <= expected_mats.size();
  end

endmodule

/* tb/tb.sv */
// Top of the quaternion to rotation matrix testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import qtrm_pkg::*;

  localparam int N_RANDOM = 800;
  localparam int HOLD_CYC = 150;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  int mismatches;
  int outstanding;
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit hold_out = 1'b0;

  quaternion_to_rotation_matrix_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  rotation_matrix_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // returns at the edge where the beat was taken
  task automatic send_quat(comp_t w, comp_t x, comp_t y, comp_t z);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x, w};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic comp_t pick_extreme();
    case ($urandom_range(0, 6))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return 16'sd1;
      5: return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic comp_t pick_comp(int kind);
    case (kind)
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 16) - 8);
      2: return pick_extreme();
      default: return comp_t'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic send_random();
    int    kind;
    comp_t q[4];
    kind = $urandom_range(0, 9);
    if (kind <= 3) kind = 0;
    else if (kind == 4) kind = 1;
    else if (kind == 5) kind = 2;
    else kind = 3;
    foreach (q[i]) q[i] = pick_comp(kind);
    // sparse quaternions, down to all zero now and then
    if ($urandom_range(0, 7) == 0)
      foreach (q[i]) if ($urandom_range(0, 1)) q[i] = '0;
    send_quat(q[0], q[1], q[2], q[3]);
  endtask

  // result side: random wait per beat, fast stretches, and one long hold-off on request
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_fast = ~rx_fast;
      if (hold_out) begin
        gap = HOLD_CYC;
        hold_out = 1'b0;
      end else begin
        gap = rx_fast ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, identity, axes, extremes, tiny and mixed-sign quaternions
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd32768, 16'sd32767, 16'sd0, 16'sd0);
    send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
    send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd1);
    send_quat(16'sd1, 16'sd1, 16'sd1, 16'sd1);
    send_quat(-16'sd1, 16'sd1, -16'sd1, 16'sd1);
    send_quat(16'sd3, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd1, 16'sd2, 16'sd0, 16'sd0);
    send_quat(16'sd5, -16'sd7, 16'sd11, -16'sd13);
    send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd1);
    send_quat(16'sd12345, -16'sd23456, 16'sd3456, -16'sd456);
    drain();

    // long output hold-off while beats keep coming: pipeline fills, input stalls
    hold_out <= 1'b1;
    tx_fast = 1'b1;
    repeat (60) send_random();
    tx_fast = 1'b0;
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 31) == 0) tx_fast = ~tx_fast;
      if (n == N_RANDOM / 2) drain();
      send_random();
    end
    drain();
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/qtrm_pkg.sv
sv/quaternion_to_rotation_matrix_core.sv
tb/rotation_matrix_checker.sv
tb/tb.sv
